FILE: sv/cscan_pkg.sv
package cscan_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int RAD_BITS       = 12;
    localparam int MAX_HITS       = 15;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SCAN   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic KIND_CIRCLE  = 1'b0;
    localparam logic KIND_SEGMENT = 1'b1;

endpackage

FILE: sv/cscan_ram.sv
module cscan_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/circle_segment_collision_scan.sv
// Collision table scanner.
// Input channel (s_valid / s_ready) carries one item per command: load writes a
// slot of the object table, remove clears its present bit, scan tests the named
// slot against every other present circle in ascending slot order.
// Result channel (m_valid / m_ready) carries one item per hit (other_slot, hit=1)
// with last on the final one, or a single no-hit item (hit=0, last=1).
// Load, remove and unknown commands give no result.
// A scan first fetches the scanned object after acceptance, then walks every
// other slot: skipping it, dropping a segment partner, running a circle/circle
// test, dropping a zero-length segment, or running a segment/circle test (with a
// 16-step restoring divide for the clamp); each hit is emitted in turn and a
// final flush item ends the scan.
// All products go through one shared registered multiplier.
// s_ready is high only while the sequencer is idle.
// A result waits in the output register while the receiver stalls; the scan
// holds at its next emission until that register frees up.
// Reset clears the present bits and all control state; the table contents need
// no clearing since only loaded slots are ever read.
module circle_segment_collision_scan import cscan_pkg::*; #(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_operation,
    input  logic [3:0]          s_slot,
    input  logic                s_kind,
    input  logic signed [15:0]  s_pos_x,
    input  logic signed [15:0]  s_pos_y,
    input  logic [11:0]         s_radius,
    input  logic signed [15:0]  s_seg_dx,
    input  logic signed [15:0]  s_seg_dy,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_other_slot,
    output logic                m_hit,
    output logic                m_last
);

    localparam int C  = COORD_BITS;
    localparam int BW = $clog2(SLOTS);
    localparam int MW = (C + 2 > 18) ? C + 2 : 18;
    localparam int PW = 2 * MW;
    localparam int AW = PW + 1;
    localparam int DW = 1 + 4 * C + RAD_BITS;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_RDA   = 5'd1;
    localparam logic [4:0] ST_NEXT  = 5'd2;
    localparam logic [4:0] ST_WAITB = 5'd3;
    localparam logic [4:0] ST_C0    = 5'd4;
    localparam logic [4:0] ST_C1    = 5'd5;
    localparam logic [4:0] ST_C2    = 5'd6;
    localparam logic [4:0] ST_C3    = 5'd7;
    localparam logic [4:0] ST_S0    = 5'd8;
    localparam logic [4:0] ST_S1    = 5'd9;
    localparam logic [4:0] ST_S2    = 5'd10;
    localparam logic [4:0] ST_S3    = 5'd11;
    localparam logic [4:0] ST_S4    = 5'd12;
    localparam logic [4:0] ST_DIV   = 5'd13;
    localparam logic [4:0] ST_S5    = 5'd14;
    localparam logic [4:0] ST_S6    = 5'd15;
    localparam logic [4:0] ST_S7    = 5'd16;
    localparam logic [4:0] ST_S8    = 5'd17;
    localparam logic [4:0] ST_S9    = 5'd18;
    localparam logic [4:0] ST_S10   = 5'd19;
    localparam logic [4:0] ST_EMIT  = 5'd20;
    localparam logic [4:0] ST_FLUSH = 5'd21;

    // table storage and present bits
    logic [SLOTS-1:0] present_reg, present_next;
    logic             ram_we;
    logic [BW-1:0]    ram_waddr, ram_raddr;
    logic [DW-1:0]    ram_wdata, ram_rdata;

    logic signed [C-1:0] in_x, in_y, in_dx, in_dy;
    logic                rd_kind;
    logic signed [C-1:0] rd_x, rd_y, rd_dx, rd_dy;
    logic [RAD_BITS-1:0] rd_r;

    // sequencer state
    logic [4:0]    state_reg, state_next;
    logic [BW-1:0] slot_reg, slot_next;
    logic [BW-1:0] b_reg, b_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [3:0]    div_reg, div_next;

    // scanned object A and pair operands
    logic                  kind_a_reg, kind_a_next;
    logic signed [C-1:0]   ax_reg, ax_next, ay_reg, ay_next;
    logic signed [C-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic [RAD_BITS-1:0]   ra_reg, ra_next, rb_reg, rb_next;
    logic [RAD_BITS:0]     rs_reg, rs_next;
    logic signed [C:0]     ddx_reg, ddx_next, ddy_reg, ddy_next;
    logic signed [C+1:0]   ex_reg, ex_next, ey_reg, ey_next;

    // shared multiplier and datapath registers
    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [PW-1:0]  prod_c, prod_reg;
    logic signed [AW-1:0]  acc_reg, acc_next, sum_c;
    logic signed [AW-1:0]  l2_reg, l2_next, rem_reg, rem_next, rem2_c;
    logic [16:0]           t_reg, t_next;
    logic signed [PW-1:0]  bias_c;
    logic signed [C+1:0]   ofs_c;

    // pending hit and output register
    logic       pend_valid_reg, pend_valid_next;
    logic [3:0] pend_reg, pend_next;
    logic       out_valid_reg, out_valid_next;
    logic [3:0] out_slot_reg, out_slot_next;
    logic       out_hit_reg, out_hit_next;
    logic       out_last_reg, out_last_next;
    logic       out_free;
    logic       at_end;

    assign in_x  = C'($unsigned(s_pos_x));
    assign in_y  = C'($unsigned(s_pos_y));
    assign in_dx = C'($unsigned(s_seg_dx));
    assign in_dy = C'($unsigned(s_seg_dy));

    assign ram_wdata = {s_kind, in_x, in_y, in_dx, in_dy, s_radius};
    assign ram_waddr = BW'(s_slot);
    assign ram_raddr = (state_reg == ST_IDLE) ? BW'(s_slot) : b_reg;

    assign rd_r    = ram_rdata[RAD_BITS-1:0];
    assign rd_dy   = ram_rdata[RAD_BITS +: C];
    assign rd_dx   = ram_rdata[RAD_BITS + C +: C];
    assign rd_y    = ram_rdata[RAD_BITS + 2*C +: C];
    assign rd_x    = ram_rdata[RAD_BITS + 3*C +: C];
    assign rd_kind = ram_rdata[RAD_BITS + 4*C];

    cscan_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign prod_c = mul_a * mul_b;
    assign sum_c  = acc_reg + AW'(prod_reg);
    assign rem2_c = rem_reg <<< 1;
    // truncate the signed Q19.16 offset toward zero
    assign bias_c = prod_reg + (prod_reg[PW-1] ? PW'(65535) : PW'(0));
    assign ofs_c  = (C+2)'(bias_c >>> 16);

    assign out_free = !out_valid_reg || m_ready;
    assign at_end   = (b_reg == BW'(SLOTS - 1));

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_other_slot = out_slot_reg;
    assign m_hit        = out_hit_reg;
    assign m_last       = out_last_reg;

    always_comb begin
        state_next      = state_reg;
        present_next    = present_reg;
        slot_next       = slot_reg;
        b_next          = b_reg;
        cnt_next        = cnt_reg;
        div_next        = div_reg;
        kind_a_next     = kind_a_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        rs_next         = rs_reg;
        ddx_next        = ddx_reg;
        ddy_next        = ddy_reg;
        ex_next         = ex_reg;
        ey_next         = ey_reg;
        acc_next        = acc_reg;
        l2_next         = l2_reg;
        rem_next        = rem_reg;
        t_next          = t_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_slot_next   = out_slot_reg;
        out_hit_next    = out_hit_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        mul_a           = '0;
        mul_b           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == OP_LOAD && 32'(s_slot) < SLOTS) begin
                        ram_we = 1'b1;
                        present_next[BW'(s_slot)] = 1'b1;
                    end else if (s_operation == OP_REMOVE && 32'(s_slot) < SLOTS) begin
                        present_next[BW'(s_slot)] = 1'b0;
                    end else if (s_operation == OP_SCAN) begin
                        pend_valid_next = 1'b0;
                        cnt_next        = '0;
                        slot_next       = BW'(s_slot);
                        if (32'(s_slot) < SLOTS && present_reg[BW'(s_slot)]) begin
                            state_next = ST_RDA;
                        end else begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end
            ST_RDA: begin
                kind_a_next = rd_kind;
                ax_next     = rd_x;
                ay_next     = rd_y;
                sx_next     = rd_dx;
                sy_next     = rd_dy;
                ra_next     = rd_r;
                b_next      = '0;
                state_next  = ST_NEXT;
            end
            ST_NEXT: begin
                if (b_reg == slot_reg || !present_reg[b_reg]) begin
                    if (at_end) state_next = ST_FLUSH;
                    else        b_next     = b_reg + 1'b1;
                end else begin
                    state_next = ST_WAITB;
                end
            end
            ST_WAITB: begin
                ddx_next = (C+1)'(rd_x) - (C+1)'(ax_reg);
                ddy_next = (C+1)'(rd_y) - (C+1)'(ay_reg);
                rb_next  = rd_r;
                rs_next  = {1'b0, ra_reg} + {1'b0, rd_r};
                if (rd_kind != KIND_CIRCLE) begin
                    // drop non-circle partners
                    if (at_end) begin
                        state_next = ST_FLUSH;
                    end else begin
                        b_next     = b_reg + 1'b1;
                        state_next = ST_NEXT;
                    end
                end else if (kind_a_reg == KIND_CIRCLE) begin
                    state_next = ST_C0;
                end else begin
                    state_next = ST_S0;
                end
            end
            ST_C0: begin
                mul_a      = MW'(ddx_reg);
                mul_b      = MW'(ddx_reg);
                state_next = ST_C1;
            end
            ST_C1: begin
                acc_next   = AW'(prod_reg);
                mul_a      = MW'(ddy_reg);
                mul_b      = MW'(ddy_reg);
                state_next = ST_C2;
            end
            ST_C2: begin
                acc_next   = sum_c;
                mul_a      = MW'(signed'({1'b0, rs_reg}));
                mul_b      = MW'(signed'({1'b0, rs_reg}));
                state_next = ST_C3;
            end
            ST_C3: begin
                if (acc_reg <= AW'(prod_reg)) begin
                    state_next = ST_EMIT;
                end else if (at_end) begin
                    state_next = ST_FLUSH;
                end else begin
                    b_next     = b_reg + 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_S0: begin
                mul_a      = MW'(sx_reg);
                mul_b      = MW'(sx_reg);
                state_next = ST_S1;
            end
            ST_S1: begin
                acc_next   = AW'(prod_reg);
                mul_a      = MW'(sy_reg);
                mul_b      = MW'(sy_reg);
                state_next = ST_S2;
            end
            ST_S2: begin
                l2_next = sum_c;
                mul_a   = MW'(sx_reg);
                mul_b   = MW'(ddx_reg);
                if (sum_c == '0) begin
                    // zero-length segment never hits
                    if (at_end) begin
                        state_next = ST_FLUSH;
                    end else begin
                        b_next     = b_reg + 1'b1;
                        state_next = ST_NEXT;
                    end
                end else begin
                    state_next = ST_S3;
                end
            end
            ST_S3: begin
                acc_next   = AW'(prod_reg);
                mul_a      = MW'(sy_reg);
                mul_b      = MW'(ddy_reg);
                state_next = ST_S4;
            end
            ST_S4: begin
                priority if (sum_c <= AW'(0)) begin
                    t_next     = '0;
                    state_next = ST_S5;
                end else if (sum_c >= l2_reg) begin
                    t_next     = 17'h10000;
                    state_next = ST_S5;
                end else begin
                    rem_next   = sum_c;
                    t_next     = '0;
                    div_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem2_c >= l2_reg) begin
                    rem_next = rem2_c - l2_reg;
                    t_next   = {t_reg[15:0], 1'b1};
                end else begin
                    rem_next = rem2_c;
                    t_next   = {t_reg[15:0], 1'b0};
                end
                div_next = div_reg + 1'b1;
                if (div_reg == 4'd15) state_next = ST_S5;
            end
            ST_S5: begin
                mul_a      = MW'(sx_reg);
                mul_b      = MW'(signed'({1'b0, t_reg}));
                state_next = ST_S6;
            end
            ST_S6: begin
                ex_next    = (C+2)'(ddx_reg) - ofs_c;
                mul_a      = MW'(sy_reg);
                mul_b      = MW'(signed'({1'b0, t_reg}));
                state_next = ST_S7;
            end
            ST_S7: begin
                ey_next    = (C+2)'(ddy_reg) - ofs_c;
                mul_a      = MW'(ex_reg);
                mul_b      = MW'(ex_reg);
                state_next = ST_S8;
            end
            ST_S8: begin
                acc_next   = AW'(prod_reg);
                mul_a      = MW'(ey_reg);
                mul_b      = MW'(ey_reg);
                state_next = ST_S9;
            end
            ST_S9: begin
                acc_next   = sum_c;
                mul_a      = MW'(signed'({1'b0, rb_reg}));
                mul_b      = MW'(signed'({1'b0, rb_reg}));
                state_next = ST_S10;
            end
            ST_S10: begin
                if (acc_reg < AW'(prod_reg)) begin
                    state_next = ST_EMIT;
                end else if (at_end) begin
                    state_next = ST_FLUSH;
                end else begin
                    b_next     = b_reg + 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_EMIT: begin
                // release the previous hit, hold this one until the next is known
                if (out_free) begin
                    out_valid_next  = pend_valid_reg;
                    out_slot_next   = pend_reg;
                    out_hit_next    = 1'b1;
                    out_last_next   = 1'b0;
                    pend_valid_next = 1'b1;
                    pend_next       = 4'(b_reg);
                    cnt_next        = cnt_reg + 1'b1;
                    if (cnt_reg == 4'(MAX_HITS - 1) || at_end) begin
                        state_next = ST_FLUSH;
                    end else begin
                        b_next     = b_reg + 1'b1;
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_slot_next  = pend_valid_reg ? pend_reg : 4'd0;
                    out_hit_next   = pend_valid_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            present_reg    <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            div_reg        <= '0;
            b_reg          <= '0;
        end else begin
            state_reg      <= state_next;
            present_reg    <= present_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            div_reg        <= div_next;
            b_reg          <= b_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg     <= slot_next;
        kind_a_reg   <= kind_a_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        rs_reg       <= rs_next;
        ddx_reg      <= ddx_next;
        ddy_reg      <= ddy_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        prod_reg     <= prod_c;
        acc_reg      <= acc_next;
        l2_reg       <= l2_next;
        rem_reg      <= rem_next;
        t_reg        <= t_next;
        pend_reg     <= pend_next;
        out_slot_reg <= out_slot_next;
        out_hit_reg  <= out_hit_next;
        out_last_reg <= out_last_next;
    end

endmodule

FILE: sv/cscan_checker.sv
module cscan_checker import cscan_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_operation,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_other_slot,
    input logic       m_hit,
    input logic       m_last
);

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_other_slot) && $stable(m_hit)
            && $stable(m_last))
        else $error("stalled result changed");

    a_nohit_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_last && m_other_slot == 4'd0)
        else $error("malformed no-hit result");

    a_scan_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == OP_SCAN |=> !s_ready)
        else $error("ready right after a scan item");

endmodule

bind circle_segment_collision_scan cscan_checker u_cscan_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_operation  (s_operation),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_other_slot (m_other_slot),
    .m_hit        (m_hit),
    .m_last       (m_last)
);
